[hw/rtl/u8d_pkg.sv]
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types, constants and helpers for the UTF-8 byte stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

	localparam int CP_W = 21;

	// lead byte patterns and masks
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_PAT  = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_PAT  = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_PAT  = 8'hF0;

	// value given for a bad lead byte ('?')
	localparam logic [CP_W-1:0] BAD_LEAD_CODE = CP_W'(8'h3F);

	// one decoded result
	typedef struct packed {
		logic            hit;
		logic [CP_W-1:0] code_point;
		logic            code_valid;
		logic            string_end;
	} u8d_result_t;

	// build a result; a zero value always means end of string
	function automatic u8d_result_t u8d_emit(input logic [CP_W-1:0] value,
		input logic ended);
		u8d_result_t r;
		r.hit = 1'b1;
		if (value == '0) begin
			r.code_point = '0;
			r.code_valid = 1'b0;
			r.string_end = 1'b1;
		end else begin
			r.code_point = value;
			r.code_valid = 1'b1;
			r.string_end = ended;
		end
		return r;
	endfunction

endpackage

[hw/rtl/utf8_byte_stream_decoder.sv]
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder
// Lenient UTF-8 decoder: one byte in, at most one code point out.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while in_stall is low: a byte lands in
// the input register, is decoded there by the sequence logic and the result,
// if any, is loaded into the output register once that register is empty or
// being taken, and it is held there until the downstream side takes it.
// Lead bytes of a multi-byte sequence give no output. A zero byte ends the
// string (flushing any partial sequence with missing bits as zero), and a
// decoded zero also sets string_end. Bad lead bytes give 0x3F. in_stall
// rises only while the output register is full and stalled and a byte is
// waiting to be decoded.
module utf8_byte_stream_decoder
	import u8d_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic [7:0]      in_byte,
	input  logic            in_valid,
	output logic            in_stall,
	output logic [CP_W-1:0] code_point,
	output logic            code_valid,
	output logic            string_end,
	output logic            out_valid,
	input  logic            out_stall
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        adv;
	u8d_result_t res;

	// decode stage may consume when the result register can take a result
	assign adv      = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
		end
	end

	// sequence decode
	u8d_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (adv),
		.byte_s1 (byte_s1),
		.res     (res)
	);

	// result register
	u8d_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (adv && res.hit),
		.res        (res),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.code_point (code_point),
		.code_valid (code_valid),
		.string_end (string_end)
	);

`ifndef SYNTHESIS
	// a non-character result always marks the end of the string
	a_novalid_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !code_valid |-> string_end)
		else $error("result without code point lacks string_end");

	// a non-character result carries a zero code point
	a_novalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !code_valid |-> code_point == '0)
		else $error("result without code point has nonzero value");

	// input stalls only because the output side is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall && valid_s1)
		else $error("input stalled without downstream back-pressure");

	// a stalled result is not overwritten
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(code_point))
		else $error("stalled result changed");
`endif

endmodule

[hw/rtl/u8d_step.sv]
// ----------------------------------------------------------------------------
// u8d_step
// Sequence state and per-byte decode; updates state on each consumed byte.
// ----------------------------------------------------------------------------
module u8d_step
	import u8d_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic [7:0]  byte_s1,
	output u8d_result_t res
);

	logic [1:0]      remain_q, remain_d;
	logic [CP_W-1:0] partial_q, partial_d;
	logic [1:0]      remain_m1;
	logic [CP_W-1:0] cont_bits;
	logic [CP_W-1:0] merged;

	// continuation byte placement
	always_comb begin
		remain_m1 = remain_q - 2'd1;
		case (remain_m1)
			2'd0:    cont_bits = CP_W'(byte_s1[5:0]);
			2'd1:    cont_bits = CP_W'(byte_s1[5:0]) << 6;
			2'd2:    cont_bits = CP_W'(byte_s1[5:0]) << 12;
			default: cont_bits = CP_W'(byte_s1[5:0]) << 18;
		endcase
		merged = partial_q | cont_bits;
	end

	// decode and next state
	always_comb begin
		res       = '0;
		remain_d  = remain_q;
		partial_d = partial_q;
		if (remain_q != 2'd0) begin
			if (byte_s1 == 8'd0) begin
				res       = u8d_emit(partial_q, 1'b1);
				remain_d  = 2'd0;
				partial_d = '0;
			end else begin
				remain_d = remain_m1;
				if (remain_m1 != 2'd0) begin
					partial_d = merged;
				end else begin
					res       = u8d_emit(merged, 1'b0);
					partial_d = '0;
				end
			end
		end else if (byte_s1 == 8'd0) begin
			res = u8d_emit('0, 1'b1);
		end else if (!byte_s1[7]) begin
			res = u8d_emit(CP_W'(byte_s1), 1'b0);
		end else if ((byte_s1 & LEAD2_MASK) == LEAD2_PAT) begin
			partial_d = CP_W'(byte_s1[4:0]) << 6;
			remain_d  = 2'd1;
		end else if ((byte_s1 & LEAD3_MASK) == LEAD3_PAT) begin
			partial_d = CP_W'(byte_s1[3:0]) << 12;
			remain_d  = 2'd2;
		end else if ((byte_s1 & LEAD4_MASK) == LEAD4_PAT) begin
			partial_d = CP_W'(byte_s1[2:0]) << 18;
			remain_d  = 2'd3;
		end else begin
			res = u8d_emit(BAD_LEAD_CODE, 1'b0);
		end
	end

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remain_q  <= 2'd0;
			partial_q <= '0;
		end else if (fire) begin
			remain_q  <= remain_d;
			partial_q <= partial_d;
		end
	end

endmodule

[hw/rtl/u8d_out_reg.sv]
// ----------------------------------------------------------------------------
// u8d_out_reg
// Result register holding one transaction for the downstream side.
// ----------------------------------------------------------------------------
module u8d_out_reg
	import u8d_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  u8d_result_t     res,
	input  logic            out_stall,
	output logic            out_valid,
	output logic [CP_W-1:0] code_point,
	output logic            code_valid,
	output logic            string_end
);

	logic            valid_q;
	logic [CP_W-1:0] cp_q;
	logic            cv_q;
	logic            end_q;

	// valid flag: set on load, cleared once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			cp_q  <= res.code_point;
			cv_q  <= res.code_valid;
			end_q <= res.string_end;
		end
	end

	assign out_valid  = valid_q;
	assign code_point = cp_q;
	assign code_valid = cv_q;
	assign string_end = end_q;

endmodule

[verif/utf8_byte_stream_decoder_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder_tb
// Self-checking bench for the lenient UTF-8 byte stream decoder.
// Bytes are pushed one per transaction. A local decoder tracks the open
// sequence and queues the code point each byte should produce. A monitor
// compares every output transaction against the head of that queue. Directed
// byte patterns come first, then random strings under varying idle
// patterns, and a long output hold-off that fills the block.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder_tb;
	import u8d_pkg::*;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            code_valid;
		logic            string_end;
	} cp_result_t;

	logic            clk       = 1'b0;
	logic            arst_n    = 1'b0;
	logic [7:0]      in_byte   = 8'h00;
	logic            in_valid  = 1'b0;
	logic            in_stall;
	logic [CP_W-1:0] code_point;
	logic            code_valid;
	logic            string_end;
	logic            out_valid;
	logic            out_stall = 1'b0;

	// decoder state tracked by the bench
	logic [1:0]      seq_left = 2'd0;
	logic [CP_W-1:0] seq_acc  = '0;

	cp_result_t expected_q[$];
	int         fail_cnt     = 0;
	int         snd_idle_pct = 0;
	int         rcv_idle_pct = 0;
	bit         hold_req     = 1'b0;
	int         hold_left    = 0;

	utf8_byte_stream_decoder i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_byte    (in_byte),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.code_point (code_point),
		.code_valid (code_valid),
		.string_end (string_end),
		.out_valid  (out_valid),
		.out_stall  (out_stall)
	);

	// clock
	always #10 clk = ~clk;

	// advance the decoder by one byte; returns 1 when a result (code point or end of string) comes out
	function automatic bit decode_byte(input logic [7:0] b, output cp_result_t r);
		logic [CP_W-1:0] val;
		logic            ended;
		bit              has;
		val   = '0;
		ended = 1'b0;
		has   = 1'b0;
		if (seq_left != 2'd0) begin
			if (b == 8'h00) begin
				// terminator cuts the sequence short
				val      = seq_acc;
				ended    = 1'b1;
				has      = 1'b1;
				seq_left = 2'd0;
				seq_acc  = '0;
			end else begin
				// any nonzero byte counts as continuation
				seq_left = seq_left - 2'd1;
				seq_acc  = seq_acc | (CP_W'(b[5:0]) << (6 * seq_left));
				if (seq_left == 2'd0) begin
					val     = seq_acc;
					has     = 1'b1;
					seq_acc = '0;
				end
			end
		end else if (b == 8'h00) begin
			ended = 1'b1;
			has   = 1'b1;
		end else if (!b[7]) begin
			val = CP_W'(b);
			has = 1'b1;
		end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
			seq_acc  = CP_W'(b[4:0]) << 6;
			seq_left = 2'd1;
		end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
			seq_acc  = CP_W'(b[3:0]) << 12;
			seq_left = 2'd2;
		end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
			seq_acc  = CP_W'(b[2:0]) << 18;
			seq_left = 2'd3;
		end else begin
			val = BAD_LEAD_CODE;
			has = 1'b1;
		end
		// a zero value always closes the string
		r.code_valid = (val != '0);
		r.code_point = val;
		r.string_end = ended || (val == '0);
		return has;
	endfunction

	// send one byte transaction; returns at the falling edge after acceptance
	task automatic send_byte(input logic [7:0] b);
		cp_result_t r;
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (decode_byte(b, r))
			expected_q.push_back(r);
		@(negedge clk);
	endtask

	// receiver stall pattern and long hold-off
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = 300;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < rcv_idle_pct);
	end

	// output monitor
	always @(posedge clk) begin
		cp_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$error("unexpected transaction: code_point %h code_valid %b string_end %b",
					code_point, code_valid, string_end);
				fail_cnt++;
			end else begin
				want = expected_q.pop_front();
				if (code_point !== want.code_point) begin
					$error("code_point: expected %h, got %h", want.code_point, code_point);
					fail_cnt++;
				end
				if (code_valid !== want.code_valid) begin
					$error("code_valid: expected %b, got %b", want.code_valid, code_valid);
					fail_cnt++;
				end
				if (string_end !== want.string_end) begin
					$error("string_end: expected %b, got %b", want.string_end, string_end);
					fail_cnt++;
				end
			end
		end
	end

	// ascii extremes and bad lead bytes
	task automatic test_single_byte();
		send_byte(8'h01);
		send_byte(8'h7F);
		send_byte(8'h80);
		send_byte(8'hF8);
		send_byte(8'hFF);
	endtask

	// two, three and four byte sequences, unchecked prefix, zero value
	task automatic test_multi_byte();
		send_byte(8'hC2); send_byte(8'hA9);
		send_byte(8'hDF); send_byte(8'h3F);
		send_byte(8'hE2); send_byte(8'h82); send_byte(8'hAC);
		send_byte(8'hF7); send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF);
		send_byte(8'hC0); send_byte(8'h80);
	endtask

	// terminator outside and inside a sequence
	task automatic test_terminator();
		send_byte(8'h00);
		send_byte(8'hE1); send_byte(8'h00);
		send_byte(8'hC0); send_byte(8'h00);
	endtask

	// random strings: mostly well-formed characters, some noise and cut sequences
	task automatic test_random_strings(input int n_bytes, input int snd_pct,
		input int rcv_pct);
		int         sent;
		int         pick;
		int         len;
		logic [7:0] lead;
		snd_idle_pct = snd_pct;
		rcv_idle_pct = rcv_pct;
		sent = 0;
		while (sent < n_bytes) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				len = $urandom_range(1, 4);
				case (len)
					1: lead = 8'($urandom_range(1, 127));
					2: lead = {3'b110, 5'($urandom)};
					3: lead = {4'b1110, 4'($urandom)};
					default: lead = {5'b11110, 3'($urandom)};
				endcase
				send_byte(lead);
				for (int k = 1; k < len; k++)
					send_byte({2'b10, 6'($urandom)});
				sent += len;
			end else if (pick < 80) begin
				send_byte(8'h00);
				sent++;
			end else if (pick < 90) begin
				// sequence cut off by the terminator
				send_byte({5'b11110, 3'($urandom)});
				sent += 2;
				if ($urandom_range(1)) begin
					send_byte(8'($urandom_range(1, 255)));
					sent++;
				end
				send_byte(8'h00);
			end else begin
				send_byte(8'($urandom));
				sent++;
			end
		end
	endtask

	// long receiver hold-off while bytes keep coming
	task automatic test_backpressure();
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		hold_req = 1'b1;
		for (int k = 0; k < 40; k++)
			send_byte(8'($urandom_range(1, 127)));
	endtask

	// main sequence
	initial begin
		snd_idle_pct = 35;
		rcv_idle_pct = 78;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_single_byte();
		test_multi_byte();
		test_terminator();
		test_random_strings(340, 35, 78);
		test_random_strings(340, 78, 35);
		test_backpressure();
		test_random_strings(340, 0, 0);
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_cnt == 0)
			$display("utf8_byte_stream_decoder: match");
		else
			$display("utf8_byte_stream_decoder: mismatch");
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("utf8_byte_stream_decoder: mismatch");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/u8d_pkg.sv
hw/rtl/u8d_step.sv
hw/rtl/u8d_out_reg.sv
hw/rtl/utf8_byte_stream_decoder.sv
verif/utf8_byte_stream_decoder_tb.sv
